/* rtl/ffp_pkg.sv */
// Shared types and constants of the field frame parser.
`default_nettype none

package ffp_pkg;

	// Framing constants
	localparam logic [7:0] PREAMBLE_BYTE   = 8'hFF;
	localparam logic [2:0] MIN_FRAME_BYTES = 3'd6;
	localparam logic [7:0] STATUS_BYTES    = 8'd2;

	// Widths of the result item
	localparam int unsigned OUT_DATA_W = 72;

	// Parse phase of the current frame
	typedef enum logic [3:0] {
		PH_PRE   = 4'd0,
		PH_ADDR  = 4'd1,
		PH_CMD   = 4'd2,
		PH_COUNT = 4'd3,
		PH_ST1   = 4'd4,
		PH_ST2   = 4'd5,
		PH_BODY  = 4'd6,
		PH_CHK   = 4'd7,
		PH_DONE  = 4'd8
	} phase_t;

	// Frame status reported with the end item
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT      = 3'd1,
		ST_PREAMBLE   = 3'd2,
		ST_BAD_START  = 3'd3,
		ST_TRUNC_HDR  = 3'd4,
		ST_TOO_LONG   = 3'd5,
		ST_TRUNC_BODY = 3'd6,
		ST_CHECKSUM   = 3'd7
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SHORT_START = 2'd0,
		REG_LONG_START  = 2'd1,
		REG_RESP_MASK   = 2'd2,
		REG_MAX_LEN     = 2'd3
	} reg_index_t;

	// Item kind on the result side
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

endpackage

`default_nettype wire

/* rtl/field_frame_parser.sv */
// Top level of the field frame parser: byte stream in, body bytes and frame reports out.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tdata = rx_byte, tlast = end_of_buffer
//  m_axis    out  tvalid / tready    tuser = item_kind, tdata = body byte or frame report
//  cfg       in   cfg_we             cfg_index, cfg_data (no read-back)
//
// One byte per cycle while the output is not stalled: an input register feeds the parse
// logic, which loads the result register in the same cycle; an item passes both registers.
// The input register doubles as a skid stage, so a byte is taken while a result waits.
// arst_n clears the configuration to its defaults, the frame state and the error counter.
// A stalled result holds; the input side stalls only when both registers are full.
`default_nettype none

module field_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// byte input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic        s_axis_tlast,   // end_of_buffer
	// result output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [ffp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [7:0] body_byte, [10:8] parse_status, [11] long_format, [12] response_flag,
	// [20:13] frame_address, [28:21] frame_command, [36:29] expansion_status_first,
	// [44:37] expansion_status_second, [52:45] data_count,
	// [68:53] checksum_error_total, [71:69] zero
	output logic             m_axis_tuser    // [0] item_kind
);
	import ffp_pkg::*;

	// Configuration registers
	logic [7:0] short_code_q, long_code_q, resp_mask_q, max_len_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state
	phase_t      phase_q, phase_n;
	logic [2:0]  seen_q, seen_n, seen_inc;
	logic [2:0]  ferr_q, ferr_n;
	logic [7:0]  remain_q, remain_n;
	logic [7:0]  xor_q, xor_n;
	logic        long_q, long_n;
	logic        resp_q, resp_n;
	logic [7:0]  addr_q, addr_n;
	logic [7:0]  cmd_q, cmd_n;
	logic [7:0]  st1_q, st1_n;
	logic [7:0]  st2_q, st2_n;
	logic [7:0]  len_q, len_n;
	logic [15:0] crc_cnt_q, crc_cnt_n;

	// Result register
	logic                  out_valid_q;
	logic                  out_user_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Parse outputs
	logic                  advance;
	logic                  fire;
	logic                  produce;
	logic                  res_user;
	logic [OUT_DATA_W-1:0] res_data;
	logic [2:0]            err;
	logic                  emit;
	logic                  do_len;
	logic [7:0]            dl;
	logic [7:0]            remain_dec;
	logic [2:0]            status;
	logic                  hdr;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign fire          = valid_s1 && advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_code_q <= 8'd2;
			long_code_q  <= 8'd130;
			resp_mask_q  <= 8'd128;
			max_len_q    <= 8'd255;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SHORT_START: short_code_q <= cfg_data;
				REG_LONG_START:  long_code_q  <= cfg_data;
				REG_RESP_MASK:   resp_mask_q  <= cfg_data;
				REG_MAX_LEN:     max_len_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted byte until the parse logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Parse one byte: next frame state and the result it causes
	always_comb begin
		seen_inc  = (seen_q < MIN_FRAME_BYTES) ? seen_q + 3'd1 : MIN_FRAME_BYTES;
		phase_n   = phase_q;
		seen_n    = seen_q;
		ferr_n    = ferr_q;
		remain_n  = remain_q;
		xor_n     = xor_q;
		long_n    = long_q;
		resp_n    = resp_q;
		addr_n    = addr_q;
		cmd_n     = cmd_q;
		st1_n     = st1_q;
		st2_n     = st2_q;
		len_n     = len_q;
		crc_cnt_n = crc_cnt_q;
		err       = ST_OK;
		emit      = 1'b0;
		do_len    = 1'b0;
		dl        = byte_s1;
		remain_dec = remain_q - 8'd1;

		unique case (phase_q)
			PH_PRE: begin
				if (byte_s1 == PREAMBLE_BYTE) begin
					if (last_s1) err = ST_PREAMBLE;
				end else if (byte_s1 == short_code_q || byte_s1 == long_code_q) begin
					long_n  = (byte_s1 == long_code_q);
					xor_n   = byte_s1;
					phase_n = PH_ADDR;
					if (last_s1) err = ST_TRUNC_HDR;
				end else begin
					err = ST_BAD_START;
				end
			end
			PH_ADDR: begin
				addr_n  = byte_s1;
				xor_n   = xor_q ^ byte_s1;
				phase_n = PH_CMD;
				if (last_s1) err = ST_TRUNC_HDR;
			end
			PH_CMD: begin
				resp_n  = |(byte_s1 & resp_mask_q);
				cmd_n   = byte_s1 & ~resp_mask_q;
				xor_n   = xor_q ^ byte_s1;
				phase_n = PH_COUNT;
				if (last_s1) err = ST_TRUNC_HDR;
			end
			PH_COUNT: begin
				xor_n = xor_q ^ byte_s1;
				if (long_q) begin
					remain_n = byte_s1;
					phase_n  = PH_ST1;
					if (last_s1) err = ST_TRUNC_HDR;
				end else begin
					do_len = 1'b1;
				end
			end
			PH_ST1: begin
				xor_n   = xor_q ^ byte_s1;
				st1_n   = byte_s1;
				phase_n = PH_ST2;
				if (last_s1) err = ST_TRUNC_HDR;
			end
			PH_ST2: begin
				xor_n  = xor_q ^ byte_s1;
				st2_n  = byte_s1;
				dl     = (remain_q > STATUS_BYTES) ? remain_q - STATUS_BYTES : 8'd0;
				do_len = 1'b1;
			end
			PH_BODY: begin
				if (last_s1) begin
					err = ST_TRUNC_BODY;
				end else begin
					emit     = 1'b1;
					xor_n    = xor_q ^ byte_s1;
					remain_n = remain_dec;
					if (remain_dec == 8'd0) phase_n = PH_CHK;
				end
			end
			PH_CHK: begin
				if (byte_s1 != xor_q) err = ST_CHECKSUM;
				phase_n = PH_DONE;
			end
			default: ;
		endcase

		// Check the data length once it is known
		if (do_len) begin
			if (dl > max_len_q) begin
				err = ST_TOO_LONG;
			end else if (last_s1) begin
				err = ST_TRUNC_BODY;
			end else begin
				len_n    = dl;
				remain_n = dl;
				phase_n  = (dl != 8'd0) ? PH_BODY : PH_CHK;
			end
		end

		// Keep the first error and stop parsing
		if (err != ST_OK) begin
			if (ferr_q == ST_OK) ferr_n = err;
			phase_n = PH_DONE;
		end

		status = (seen_inc < MIN_FRAME_BYTES) ? ST_SHORT : ferr_n;
		hdr    = (status != ST_SHORT);
		if (last_s1 && status == ST_CHECKSUM) crc_cnt_n = crc_cnt_q + 16'd1;

		// Build the result item
		res_data = '0;
		res_user = KIND_DATA;
		if (last_s1) begin
			res_user        = KIND_END;
			res_data[10:8]  = status;
			res_data[11]    = hdr & long_n;
			res_data[12]    = hdr & resp_n;
			res_data[20:13] = hdr ? addr_n : 8'd0;
			res_data[28:21] = hdr ? cmd_n : 8'd0;
			res_data[36:29] = hdr ? st1_n : 8'd0;
			res_data[44:37] = hdr ? st2_n : 8'd0;
			res_data[52:45] = (status == ST_OK || status == ST_CHECKSUM) ? len_n : 8'd0;
			res_data[68:53] = crc_cnt_n;
		end else begin
			res_data[7:0] = byte_s1;
		end
		produce = last_s1 || emit;

		// Start over after the last byte of a buffer
		if (last_s1) begin
			phase_n  = PH_PRE;
			seen_n   = 3'd0;
			ferr_n   = ST_OK;
			remain_n = 8'd0;
			xor_n    = 8'd0;
			long_n   = 1'b0;
			resp_n   = 1'b0;
			addr_n   = 8'd0;
			cmd_n    = 8'd0;
			st1_n    = 8'd0;
			st2_n    = 8'd0;
			len_n    = 8'd0;
		end else begin
			seen_n = seen_inc;
		end
	end

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PRE;
			seen_q    <= 3'd0;
			ferr_q    <= ST_OK;
			remain_q  <= 8'd0;
			xor_q     <= 8'd0;
			long_q    <= 1'b0;
			resp_q    <= 1'b0;
			addr_q    <= 8'd0;
			cmd_q     <= 8'd0;
			st1_q     <= 8'd0;
			st2_q     <= 8'd0;
			len_q     <= 8'd0;
			crc_cnt_q <= 16'd0;
		end else if (fire) begin
			phase_q   <= phase_n;
			seen_q    <= seen_n;
			ferr_q    <= ferr_n;
			remain_q  <= remain_n;
			xor_q     <= xor_n;
			long_q    <= long_n;
			resp_q    <= resp_n;
			addr_q    <= addr_n;
			cmd_q     <= cmd_n;
			st1_q     <= st1_n;
			st2_q     <= st2_n;
			len_q     <= len_n;
			crc_cnt_q <= crc_cnt_n;
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			out_user_q <= res_user;
			out_data_q <= res_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/ffp_checker.sv */
// Port-level checks of the field frame parser and their binding.
`default_nettype none

module ffp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [ffp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);
	import ffp_pkg::*;

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	// A body byte item carries nothing but the byte
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_DATA |-> m_axis_tdata[OUT_DATA_W-1:8] == '0)
		else $error("body byte item has report fields set");

	// A too-short frame reports no header and no length
	a_short_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_END && m_axis_tdata[10:8] == ST_SHORT |->
			m_axis_tdata[52:11] == '0 && m_axis_tdata[7:0] == 8'd0)
		else $error("short frame report carries header fields");

	// The data count appears only with a good or checksum-failed frame
	a_count_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_END && m_axis_tdata[52:45] != 8'd0 |->
			m_axis_tdata[10:8] == ST_OK || m_axis_tdata[10:8] == ST_CHECKSUM)
		else $error("data count reported with an error status");

endmodule

bind field_frame_parser ffp_checker u_ffp_checker (.*);

`default_nettype wire
